// File: rtl/pmm_pkg.sv
// ---------------------------------------------------------------------------
// pmm_pkg: shared constants and helpers for the PMNS polynomial multiplier
// Reduction matrices, coefficient widths and 26-bit partial product merges.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmm_pkg;

  localparam int unsigned NC     = 6;   // coefficients per polynomial
  localparam int unsigned NP     = 36;  // coefficient pairs
  localparam int unsigned NCOEF  = 11;  // coefficients of the raw product
  localparam int unsigned CW     = 52;  // input coefficient width
  localparam int unsigned HW     = 26;  // half width of a coefficient
  localparam int unsigned AW     = 64;  // accumulator width
  localparam int unsigned NSTAGE = 11;  // register stages

  // Montgomery matrix, row j column i
  localparam logic [51:0] KQ [NC][NC] = '{
    '{52'h7a26c3751d730, 52'h48a4ee93d8d56, 52'hf1b78fd9c173d,
      52'hce748ddd1b6df, 52'h6909ed6937fcd, 52'hc11536d3b0ede},
    '{52'hc11536d3b0ede, 52'h3b3bfa48ce60e, 52'h48a4ee93d8d56,
      52'hf1b78fd9c173d, 52'hce748ddd1b6df, 52'h6909ed6937fcd},
    '{52'h6909ed6937fcd, 52'h2a1f243ce8eab, 52'h3b3bfa48ce60e,
      52'h48a4ee93d8d56, 52'hf1b78fd9c173d, 52'hce748ddd1b6df},
    '{52'hce748ddd1b6df, 52'h377e7b46536ac, 52'h2a1f243ce8eab,
      52'h3b3bfa48ce60e, 52'h48a4ee93d8d56, 52'hf1b78fd9c173d},
    '{52'hf1b78fd9c173d, 52'hc02c1db6dce1c, 52'h377e7b46536ac,
      52'h2a1f243ce8eab, 52'h3b3bfa48ce60e, 52'h48a4ee93d8d56},
    '{52'h48a4ee93d8d56, 52'h3a5c7e6d9a493, 52'hc02c1db6dce1c,
      52'h377e7b46536ac, 52'h2a1f243ce8eab, 52'h3b3bfa48ce60e}
  };

  // Reduction matrix applied to Q, row j column i
  localparam logic [51:0] KZ [NC][NC] = '{
    '{52'h579a44c411d, 52'h50e3ccdfa67, 52'h6e4d0330fa4,
      52'h2f18fb678af, 52'h174c74f7a18, 52'h46d550f9a0},
    '{52'h46d550f9a0, 52'h5c0799d3abd, 52'h50e3ccdfa67,
      52'h6e4d0330fa4, 52'h2f18fb678af, 52'h174c74f7a18},
    '{52'h174c74f7a18, 52'h1bb9ca073b8, 52'h5c0799d3abd,
      52'h50e3ccdfa67, 52'h6e4d0330fa4, 52'h2f18fb678af},
    '{52'h2f18fb678af, 52'h4665705f2c7, 52'h1bb9ca073b8,
      52'h5c0799d3abd, 52'h50e3ccdfa67, 52'h6e4d0330fa4},
    '{52'h6e4d0330fa4, 52'h9d65fe98853, 52'h4665705f2c7,
      52'h1bb9ca073b8, 52'h5c0799d3abd, 52'h50e3ccdfa67},
    '{52'h50e3ccdfa67, 52'hbf30d010a0b, 52'h9d65fe98853,
      52'h4665705f2c7, 52'h1bb9ca073b8, 52'h5c0799d3abd}
  };

  // Merge four 26x26 partial products into {hi, lo} of the 104-bit product
  function automatic logic [103:0] merge_full(input logic [51:0] p00, input logic [51:0] p01,
                                              input logic [51:0] p10, input logic [51:0] p11);
    logic [52:0] mid;
    logic [52:0] t;
    logic [51:0] hi;
    mid = {1'b0, p01} + {1'b0, p10};
    t   = {1'b0, p00} + {1'b0, mid[25:0], 26'd0};
    hi  = p11 + 52'(mid[52:26]) + 52'(t[52]);
    return {hi, t[51:0]};
  endfunction

  // Low 52 bits of a product from its three low partial products
  function automatic logic [51:0] merge_low(input logic [51:0] p00, input logic [51:0] p01,
                                            input logic [51:0] p10);
    logic [51:0] mid;
    mid = p01 + p10;
    return p00 + {mid[25:0], 26'd0};
  endfunction

endpackage

`default_nettype wire

// File: rtl/pmns_poly_modmul_6x52.sv
// ---------------------------------------------------------------------------
// pmns_poly_modmul_6x52: pipelined PMNS polynomial modular multiplier
// Multiplies two six-coefficient polynomials modulo X^6-X-1 and applies
// Montgomery internal reduction, one transfer per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+---------------------------
// in      | input     | in_valid_i/in_ready_o  | a0_i..a5_i, b0_i..b5_i (52b)
// out     | output    | out_valid_o/out_ready_i| r0_o..r5_o (64b)
//
// One item enters per cycle while the output is not stalled; the
// datapath has eleven register stages (26x26 partial products, merge,
// accumulate, fold, Q, Q*KZ, recombine).
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while its successor is full and stalled, so empty
// stages keep filling while a result waits at the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmns_poly_modmul_6x52 (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [51:0] a0_i,
  input  wire  [51:0] a1_i,
  input  wire  [51:0] a2_i,
  input  wire  [51:0] a3_i,
  input  wire  [51:0] a4_i,
  input  wire  [51:0] a5_i,
  input  wire  [51:0] b0_i,
  input  wire  [51:0] b1_i,
  input  wire  [51:0] b2_i,
  input  wire  [51:0] b3_i,
  input  wire  [51:0] b4_i,
  input  wire  [51:0] b5_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [63:0] r0_o,
  output logic [63:0] r1_o,
  output logic [63:0] r2_o,
  output logic [63:0] r3_o,
  output logic [63:0] r4_o,
  output logic [63:0] r5_o
);

  localparam int unsigned NS = pmm_pkg::NSTAGE;

  // Stage valid bits and load enables; stage k loads when empty or draining
  logic [NS:1]   v_q;
  logic [NS+1:1] en;
  logic [NS:1]   v_in;

  always_comb begin
    en[NS+1] = out_ready_i;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in[1] = in_valid_i;
    for (int k = 2; k <= NS; k++) begin
      v_in[k] = v_q[k-1];
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  logic [51:0] a_in [pmm_pkg::NC];
  logic [51:0] b_in [pmm_pkg::NC];

  always_comb begin
    a_in[0] = a0_i; a_in[1] = a1_i; a_in[2] = a2_i;
    a_in[3] = a3_i; a_in[4] = a4_i; a_in[5] = a5_i;
    b_in[0] = b0_i; b_in[1] = b1_i; b_in[2] = b2_i;
    b_in[3] = b3_i; b_in[4] = b4_i; b_in[5] = b5_i;
  end

  // Stage 1: 26x26 partial products of a_i * b_j, pair index i*6+j
  logic [51:0] pp1_q [pmm_pkg::NP][4];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < pmm_pkg::NC; i++) begin
        for (int j = 0; j < pmm_pkg::NC; j++) begin
          pp1_q[i*6+j][0] <= a_in[i][25:0]  * b_in[j][25:0];
          pp1_q[i*6+j][1] <= a_in[i][25:0]  * b_in[j][51:26];
          pp1_q[i*6+j][2] <= a_in[i][51:26] * b_in[j][25:0];
          pp1_q[i*6+j][3] <= a_in[i][51:26] * b_in[j][51:26];
        end
      end
    end
  end

  // Stage 2: low and high halves of each product
  logic [103:0] prod2_q [pmm_pkg::NP];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int p = 0; p < pmm_pkg::NP; p++) begin
        prod2_q[p] <= pmm_pkg::merge_full(pp1_q[p][0], pp1_q[p][1], pp1_q[p][2], pp1_q[p][3]);
      end
    end
  end

  // Stage 3: accumulate halves per product degree
  logic [63:0] cl_d [pmm_pkg::NCOEF];
  logic [63:0] ch_d [pmm_pkg::NCOEF];
  logic [63:0] cl_q [pmm_pkg::NCOEF];
  logic [63:0] ch_q [pmm_pkg::NCOEF];

  always_comb begin
    for (int k = 0; k < pmm_pkg::NCOEF; k++) begin
      cl_d[k] = '0;
      ch_d[k] = '0;
    end
    for (int i = 0; i < pmm_pkg::NC; i++) begin
      for (int j = 0; j < pmm_pkg::NC; j++) begin
        cl_d[i+j] = cl_d[i+j] + 64'(prod2_q[i*6+j][51:0]);
        ch_d[i+j] = ch_d[i+j] + 64'(prod2_q[i*6+j][103:52]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      cl_q <= cl_d;
      ch_q <= ch_d;
    end
  end

  // Stage 4: fold degrees 6..10 back with X^6 = X + 1
  logic [63:0] al_d [pmm_pkg::NC];
  logic [63:0] ah_d [pmm_pkg::NC];

  always_comb begin
    for (int i = 0; i < pmm_pkg::NC; i++) begin
      al_d[i] = cl_q[i];
      ah_d[i] = ch_q[i];
      if (i + pmm_pkg::NC < pmm_pkg::NCOEF) begin
        al_d[i] = al_d[i] + cl_q[i+6];
        ah_d[i] = ah_d[i] + ch_q[i+6];
      end
      if (i >= 1) begin
        al_d[i] = al_d[i] + cl_q[i+5];
        ah_d[i] = ah_d[i] + ch_q[i+5];
      end
    end
  end

  // Carry the folded accumulators along to the recombine stage
  logic [63:0] al_q [4:9][pmm_pkg::NC];
  logic [63:0] ah_q [4:9][pmm_pkg::NC];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      al_q[4] <= al_d;
      ah_q[4] <= ah_d;
    end
    for (int k = 5; k <= 9; k++) begin
      if (en[k]) begin
        al_q[k] <= al_q[k-1];
        ah_q[k] <= ah_q[k-1];
      end
    end
  end

  // Stage 5: low partial products of L * KQ, pair index j*6+i
  logic [51:0] pq5_q [pmm_pkg::NP][3];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int j = 0; j < pmm_pkg::NC; j++) begin
        for (int i = 0; i < pmm_pkg::NC; i++) begin
          pq5_q[j*6+i][0] <= al_q[4][j][25:0]  * pmm_pkg::KQ[j][i][25:0];
          pq5_q[j*6+i][1] <= al_q[4][j][25:0]  * pmm_pkg::KQ[j][i][51:26];
          pq5_q[j*6+i][2] <= al_q[4][j][51:26] * pmm_pkg::KQ[j][i][25:0];
        end
      end
    end
  end

  // Stage 6: low 52 bits of each KQ product
  logic [51:0] ql6_q [pmm_pkg::NP];

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int p = 0; p < pmm_pkg::NP; p++) begin
        ql6_q[p] <= pmm_pkg::merge_low(pq5_q[p][0], pq5_q[p][1], pq5_q[p][2]);
      end
    end
  end

  // Stage 7: Q, column sums modulo 2^52
  logic [51:0] q_d [pmm_pkg::NC];
  logic [51:0] q_q [pmm_pkg::NC];

  always_comb begin
    for (int i = 0; i < pmm_pkg::NC; i++) begin
      q_d[i] = '0;
      for (int j = 0; j < pmm_pkg::NC; j++) begin
        q_d[i] = q_d[i] + ql6_q[j*6+i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      q_q <= q_d;
    end
  end

  // Stage 8: partial products of KZ * Q, pair index j*6+i
  logic [51:0] pz8_q [pmm_pkg::NP][4];

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      for (int j = 0; j < pmm_pkg::NC; j++) begin
        for (int i = 0; i < pmm_pkg::NC; i++) begin
          pz8_q[j*6+i][0] <= pmm_pkg::KZ[j][i][25:0]  * q_q[j][25:0];
          pz8_q[j*6+i][1] <= pmm_pkg::KZ[j][i][25:0]  * q_q[j][51:26];
          pz8_q[j*6+i][2] <= pmm_pkg::KZ[j][i][51:26] * q_q[j][25:0];
          pz8_q[j*6+i][3] <= pmm_pkg::KZ[j][i][51:26] * q_q[j][51:26];
        end
      end
    end
  end

  // Stage 9: halves of each KZ product
  logic [103:0] pz9_q [pmm_pkg::NP];

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      for (int p = 0; p < pmm_pkg::NP; p++) begin
        pz9_q[p] <= pmm_pkg::merge_full(pz8_q[p][0], pz8_q[p][1], pz8_q[p][2], pz8_q[p][3]);
      end
    end
  end

  // Stage 10: add Q * KZ into both accumulators
  logic [63:0] tl_d [pmm_pkg::NC];
  logic [63:0] th_d [pmm_pkg::NC];
  logic [63:0] tl_q [pmm_pkg::NC];
  logic [63:0] th_q [pmm_pkg::NC];

  always_comb begin
    for (int i = 0; i < pmm_pkg::NC; i++) begin
      tl_d[i] = al_q[9][i];
      th_d[i] = ah_q[9][i];
      for (int j = 0; j < pmm_pkg::NC; j++) begin
        tl_d[i] = tl_d[i] + 64'(pz9_q[j*6+i][51:0]);
        th_d[i] = th_d[i] + 64'(pz9_q[j*6+i][103:52]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      tl_q <= tl_d;
      th_q <= th_d;
    end
  end

  // Stage 11: recombine high + (low >> 52) into the output register
  logic [63:0] r_q [pmm_pkg::NC];

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      for (int i = 0; i < pmm_pkg::NC; i++) begin
        r_q[i] <= th_q[i] + 64'(tl_q[i][63:52]);
      end
    end
  end

  assign r0_o = r_q[0];
  assign r1_o = r_q[1];
  assign r2_o = r_q[2];
  assign r3_o = r_q[3];
  assign r4_o = r_q[4];
  assign r5_o = r_q[5];

  // The input side only backs up when the output is stalled
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // An item loaded into the last stage shows up at the output
  a_last_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[NS] && v_q[NS-1]) |=> out_valid_o)
    else $error("result lost at output stage");

  // A drained output with nothing behind it goes empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !v_q[NS-1]) |=> !out_valid_o)
    else $error("result repeated at output");

endmodule

`default_nettype wire
